// ===== src/qslerp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quaternion slerp package
// Shared widths, fixed-point constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package qslerp_pkg;

    // Defaults for the top-level parameters.
    localparam int COMP_BITS_DEF    = 16;
    localparam int CORDIC_STEPS_DEF = 18;

    // Internal datapath widths.
    localparam int CW     = 34;   // CORDIC x, y and angle registers
    localparam int SQ_W   = 64;   // square-root remainder
    localparam int ROOT_W = 31;   // square-root result, up to 2^30
    localparam int DIV_W  = 64;   // divider remainder
    localparam int Q_BITS = 33;   // quotient bits produced by the divider chain
    localparam int TB_W   = 16;   // blend fraction width

    // Fixed-point constants (angles and sines in Q.30).
    localparam logic [CW-1:0]     SLERP_LIM = 34'd1072668082; // 1.0 - 0.001 in Q.30
    localparam logic [CW-1:0]     CORDIC_K  = 34'd652032874;  // inverse CORDIC gain in Q.30
    localparam logic [TB_W:0]     BLEND_ONE = 17'd32768;
    localparam logic [Q_BITS-1:0] W_MAX     = 33'h080000000;  // 2.0 in Q.30

    // Arctangent of 2^-i in Q.30, truncated.
    localparam logic [31:0] ATAN_Q30 [32] = '{
        32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
        32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
        32'd1048575, 32'd524287, 32'd262143, 32'd131071, 32'd65535, 32'd32767,
        32'd16383, 32'd8191, 32'd4095, 32'd2047, 32'd1023, 32'd511, 32'd255,
        32'd127, 32'd63, 32'd31, 32'd15, 32'd7, 32'd3, 32'd1, 32'd0, 32'd0
    };

endpackage

// ===== src/quaternion_slerp.sv =====
`timescale 1ns / 1ps
// Throughput: one transaction per cycle unless the output stalls; every stage of the cell chains
// (square root, vectoring CORDIC, rotation CORDIC, divider) moves each cycle.
// The whole pipeline holds while a finished result is stalled at the output.
// Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Quaternion slerp
// Pipelined fixed-point spherical linear interpolation of two quaternions.
// ----------------------------------------------------------------------------
module quaternion_slerp #(
    parameter int COMP_BITS    = qslerp_pkg::COMP_BITS_DEF,
    parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic signed [COMP_BITS-1:0]    from_x,
    input  logic signed [COMP_BITS-1:0]    from_y,
    input  logic signed [COMP_BITS-1:0]    from_z,
    input  logic signed [COMP_BITS-1:0]    from_s,
    input  logic signed [COMP_BITS-1:0]    to_x,
    input  logic signed [COMP_BITS-1:0]    to_y,
    input  logic signed [COMP_BITS-1:0]    to_z,
    input  logic signed [COMP_BITS-1:0]    to_s,
    input  logic [qslerp_pkg::TB_W-1:0]    blend,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [COMP_BITS-1:0]    res_x,
    output logic signed [COMP_BITS-1:0]    res_y,
    output logic signed [COMP_BITS-1:0]    res_z,
    output logic signed [COMP_BITS-1:0]    res_s
);
    import qslerp_pkg::*;

    localparam int CB     = COMP_BITS;
    localparam int F      = CB - 1;
    localparam int SH_L   = (F <= 30) ? (30 - F) : 0;
    localparam int SH_R   = (F > 30) ? (F - 30) : 0;
    localparam int AW     = 4 * CB;
    localparam int BW     = 4 * (CB + 1);
    localparam int T_LSB  = AW + BW;
    localparam int SW     = AW + BW + TB_W + 1;
    localparam int SL_BIT = SW - 1;
    localparam int PW     = CB + 34;
    localparam logic signed [PW-1:0] RND  = PW'(64'd536870912);
    localparam logic signed [PW-1:0] MAXV = PW'((65'd1 << F) - 65'd1);
    localparam logic signed [PW-1:0] MINV = -MAXV - PW'(1);

    // Global advance: everything moves unless a finished result is stalled.
    logic adv;
    assign adv      = !(out_valid && out_stall);
    assign in_stall = !adv;

    // ------------------------------------------------------------------
    // Input stage: capture components, clamp blend, form the products.
    // ------------------------------------------------------------------
    logic signed [CB-1:0]   a_in [4];
    logic signed [CB-1:0]   b_in [4];
    logic                   p_vld_reg;
    logic signed [CB-1:0]   a_reg [4];
    logic signed [CB-1:0]   b_reg [4];
    logic [TB_W-1:0]        t_reg, t_next;
    logic signed [2*CB-1:0] prod_reg [4];
    logic signed [2*CB-1:0] prod_next [4];

    assign a_in[0] = from_x;
    assign a_in[1] = from_y;
    assign a_in[2] = from_z;
    assign a_in[3] = from_s;
    assign b_in[0] = to_x;
    assign b_in[1] = to_y;
    assign b_in[2] = to_z;
    assign b_in[3] = to_s;

    always_comb
    begin
        t_next = ({1'b0, blend} > BLEND_ONE) ? BLEND_ONE[TB_W-1:0] : blend;
        for (int k = 0; k < 4; k++)
        begin
            prod_next[k] = a_in[k] * b_in[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_reg    <= a_in;
            b_reg    <= b_in;
            t_reg    <= t_next;
            prod_reg <= prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Dot stage: sum, sign fold, rescale to Q.30, branch decision.
    // ------------------------------------------------------------------
    logic signed [CB:0]   sh [4];
    logic signed [CB+2:0] dot, dabs;
    logic                 neg;
    logic signed [CB:0]   b_ext [4];
    logic signed [CB:0]   bn [4];
    logic [63:0]          dwide, c30_full;
    logic [CW-1:0]        c30;
    logic                 slerp;
    logic                 d_vld_reg;
    logic [CW-1:0]        d_c30_reg;
    logic [SW-1:0]        d_side_reg, d_side_next;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            sh[k] = prod_reg[k][2*CB-1:F];
        end
        dot      = (CB+3)'(sh[0]) + (CB+3)'(sh[1]) + (CB+3)'(sh[2]) + (CB+3)'(sh[3]);
        neg      = dot[CB+2];
        dabs     = neg ? -dot : dot;
        dwide    = 64'(dabs);
        c30_full = (dwide << SH_L) >> SH_R;
        c30      = c30_full[CW-1:0];
        slerp    = (c30 < SLERP_LIM);
        for (int k = 0; k < 4; k++)
        begin
            b_ext[k] = (CB+1)'(b_reg[k]);
            bn[k]    = neg ? -b_ext[k] : b_ext[k];
            d_side_next[k*CB +: CB]           = a_reg[k];
            d_side_next[AW + k*(CB+1) +: CB+1] = bn[k];
        end
        d_side_next[T_LSB +: TB_W] = t_reg;
        d_side_next[SL_BIT]        = slerp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            d_vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_c30_reg  <= c30;
            d_side_reg <= d_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Square stage: 1 - cos^2 in Q.60 (only meaningful when slerp is taken).
    // ------------------------------------------------------------------
    logic [59:0]      csq;
    logic             q_vld_reg;
    logic [SQ_W-1:0]  q_sq_reg, q_sq_next;
    logic [CW+SW-1:0] q_side_reg;

    always_comb
    begin
        csq       = d_c30_reg[29:0] * d_c30_reg[29:0];
        q_sq_next = (SQ_W'(1) << 60) - SQ_W'(csq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            q_vld_reg <= d_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            q_sq_reg   <= q_sq_next;
            q_side_reg <= {d_c30_reg, d_side_reg};
        end
    end

    // ------------------------------------------------------------------
    // Square-root chain: sin(omega) in Q.30, one bit per cell.
    // ------------------------------------------------------------------
    logic              sq_vld [ROOT_W+1];
    logic [SQ_W-1:0]   sq_rem [ROOT_W+1];
    logic [ROOT_W-1:0] sq_root [ROOT_W+1];
    logic [CW+SW-1:0]  sq_side [ROOT_W+1];

    assign sq_vld[0]  = q_vld_reg;
    assign sq_rem[0]  = q_sq_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = q_side_reg;

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_sqrt
        qslerp_sqrt_cell #(
            .BIT    (ROOT_W - 1 - i),
            .SIDE_W (CW + SW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .vld_in   (sq_vld[i]),
            .rem_in   (sq_rem[i]),
            .root_in  (sq_root[i]),
            .side_in  (sq_side[i]),
            .vld_out  (sq_vld[i+1]),
            .rem_out  (sq_rem[i+1]),
            .root_out (sq_root[i+1]),
            .side_out (sq_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Vectoring chain: omega = atan2(sin, cos).
    // ------------------------------------------------------------------
    logic                 vc_vld [CORDIC_STEPS+1];
    logic signed [CW-1:0] vc_x [CORDIC_STEPS+1];
    logic signed [CW-1:0] vc_y [CORDIC_STEPS+1];
    logic signed [CW-1:0] vc_z [CORDIC_STEPS+1];
    logic [ROOT_W+SW-1:0] vc_side [CORDIC_STEPS+1];

    assign vc_vld[0]  = sq_vld[ROOT_W];
    assign vc_x[0]    = signed'(sq_side[ROOT_W][CW+SW-1:SW]);
    assign vc_y[0]    = signed'(CW'(sq_root[ROOT_W]));
    assign vc_z[0]    = '0;
    assign vc_side[0] = {sq_root[ROOT_W], sq_side[ROOT_W][SW-1:0]};

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_vec
        qslerp_vec_cell #(
            .STEP   (i),
            .SIDE_W (ROOT_W + SW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .vld_in   (vc_vld[i]),
            .x_in     (vc_x[i]),
            .y_in     (vc_y[i]),
            .z_in     (vc_z[i]),
            .side_in  (vc_side[i]),
            .vld_out  (vc_vld[i+1]),
            .x_out    (vc_x[i+1]),
            .y_out    (vc_y[i+1]),
            .z_out    (vc_z[i+1]),
            .side_out (vc_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Angle stage: (1-t)*omega and t*omega.
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0]    om;
    logic [TB_W-1:0]      tv;
    logic [TB_W:0]        t0w;
    logic [47:0]          m0, m1;
    logic                 th_vld_reg;
    logic [ROOT_W-1:0]    th0_reg, th0_next, th1_reg, th1_next;
    logic [ROOT_W+SW-1:0] th_side_reg;

    always_comb
    begin
        om       = vc_z[CORDIC_STEPS][CW-1] ? '0 : vc_z[CORDIC_STEPS][ROOT_W-1:0];
        tv       = vc_side[CORDIC_STEPS][T_LSB +: TB_W];
        t0w      = BLEND_ONE - {1'b0, tv};
        m0       = t0w * om;
        m1       = tv * om;
        th0_next = m0[ROOT_W+14:15];
        th1_next = m1[ROOT_W+14:15];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            th_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            th_vld_reg <= vc_vld[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            th0_reg     <= th0_next;
            th1_reg     <= th1_next;
            th_side_reg <= vc_side[CORDIC_STEPS];
        end
    end

    // ------------------------------------------------------------------
    // Rotation chain: both sines in parallel lanes.
    // ------------------------------------------------------------------
    logic                 rc_vld [CORDIC_STEPS+1];
    logic signed [CW-1:0] rc_x [CORDIC_STEPS+1][2];
    logic signed [CW-1:0] rc_y [CORDIC_STEPS+1][2];
    logic signed [CW-1:0] rc_z [CORDIC_STEPS+1][2];
    logic [ROOT_W+SW-1:0] rc_side [CORDIC_STEPS+1];

    assign rc_vld[0]  = th_vld_reg;
    assign rc_x[0][0] = signed'(CORDIC_K);
    assign rc_x[0][1] = signed'(CORDIC_K);
    assign rc_y[0][0] = '0;
    assign rc_y[0][1] = '0;
    assign rc_z[0][0] = signed'(CW'(th0_reg));
    assign rc_z[0][1] = signed'(CW'(th1_reg));
    assign rc_side[0] = th_side_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        qslerp_rot_cell #(
            .STEP   (i),
            .SIDE_W (ROOT_W + SW)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .vld_in   (rc_vld[i]),
            .x_in     (rc_x[i]),
            .y_in     (rc_y[i]),
            .z_in     (rc_z[i]),
            .side_in  (rc_side[i]),
            .vld_out  (rc_vld[i+1]),
            .x_out    (rc_x[i+1]),
            .y_out    (rc_y[i+1]),
            .z_out    (rc_z[i+1]),
            .side_out (rc_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Divide setup: clamp the sines, scale to Q.60, flag huge quotients.
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] sn_v;
    logic [ROOT_W-1:0] sin_v [2];
    logic              v_vld_reg;
    logic [ROOT_W-1:0] v_den_reg;
    logic [DIV_W-1:0]  v_rem_reg [2];
    logic [DIV_W-1:0]  v_rem_next [2];
    logic [1:0]        v_ovf_next;
    logic [SW+1:0]     v_side_reg;

    always_comb
    begin
        sn_v = rc_side[CORDIC_STEPS][ROOT_W+SW-1:SW];
        for (int l = 0; l < 2; l++)
        begin
            sin_v[l]      = rc_y[CORDIC_STEPS][l][CW-1] ? '0
                                                        : rc_y[CORDIC_STEPS][l][ROOT_W-1:0];
            v_rem_next[l] = DIV_W'(sin_v[l]) << 30;
            v_ovf_next[l] = ({3'b000, sin_v[l]} >= {sn_v, 3'b000});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_vld_reg <= rc_vld[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            v_den_reg  <= sn_v;
            v_rem_reg  <= v_rem_next;
            v_side_reg <= {v_ovf_next, rc_side[CORDIC_STEPS][SW-1:0]};
        end
    end

    // ------------------------------------------------------------------
    // Divider chain: weight = sin * 2^30 / sin(omega), one bit per cell.
    // ------------------------------------------------------------------
    logic              dc_vld [Q_BITS+1];
    logic [ROOT_W-1:0] dc_den [Q_BITS+1];
    logic [DIV_W-1:0]  dc_rem [Q_BITS+1][2];
    logic [Q_BITS-1:0] dc_q [Q_BITS+1][2];
    logic [SW+1:0]     dc_side [Q_BITS+1];

    assign dc_vld[0]  = v_vld_reg;
    assign dc_den[0]  = v_den_reg;
    assign dc_rem[0]  = v_rem_reg;
    assign dc_q[0][0] = '0;
    assign dc_q[0][1] = '0;
    assign dc_side[0] = v_side_reg;

    for (genvar i = 0; i < Q_BITS; i++)
    begin : g_div
        qslerp_div_cell #(
            .K      (Q_BITS - 1 - i),
            .SIDE_W (SW + 2)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .vld_in   (dc_vld[i]),
            .den_in   (dc_den[i]),
            .rem_in   (dc_rem[i]),
            .q_in     (dc_q[i]),
            .side_in  (dc_side[i]),
            .vld_out  (dc_vld[i+1]),
            .den_out  (dc_den[i+1]),
            .rem_out  (dc_rem[i+1]),
            .q_out    (dc_q[i+1]),
            .side_out (dc_side[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Weight stage: pick slerp or linear weights, multiply components.
    // ------------------------------------------------------------------
    logic [SW+1:0]         ws;
    logic [TB_W-1:0]       tw;
    logic                  use_sl;
    logic [31:0]           wt [2];
    logic [31:0]           lw [2];
    logic                  sat;
    logic signed [32:0]    wsg [2];
    logic signed [CB:0]    bw [4];
    logic signed [CB-1:0]  aw [4];
    logic                  w_vld_reg;
    logic signed [PW-1:0]  pa_reg [4];
    logic signed [PW-1:0]  pa_next [4];
    logic signed [PW-1:0]  pb_reg [4];
    logic signed [PW-1:0]  pb_next [4];

    always_comb
    begin
        ws     = dc_side[Q_BITS];
        tw     = ws[T_LSB +: TB_W];
        use_sl = ws[SL_BIT] && (dc_den[Q_BITS] != '0);
        lw[0]  = {1'b0, TB_W'(BLEND_ONE - {1'b0, tw}), 15'd0};
        lw[1]  = {1'b0, tw, 15'd0};
        for (int l = 0; l < 2; l++)
        begin
            sat    = ws[SW + l] || (dc_q[Q_BITS][l] > W_MAX);
            wt[l]  = !use_sl ? lw[l] : (sat ? W_MAX[31:0] : dc_q[Q_BITS][l][31:0]);
            wsg[l] = signed'({1'b0, wt[l]});
        end
        for (int k = 0; k < 4; k++)
        begin
            aw[k]      = ws[k*CB +: CB];
            bw[k]      = ws[AW + k*(CB+1) +: CB+1];
            pa_next[k] = wsg[0] * aw[k];
            pb_next[k] = wsg[1] * bw[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            w_vld_reg <= dc_vld[Q_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: round each term, add, saturate.
    // ------------------------------------------------------------------
    logic signed [PW-1:0] ta [4];
    logic signed [PW-1:0] tb [4];
    logic signed [PW-1:0] rs [4];
    logic signed [CB-1:0] res_next [4];
    logic signed [CB-1:0] res_reg [4];
    logic                 o_vld_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            ta[k] = (pa_reg[k] + RND) >>> 30;
            tb[k] = (pb_reg[k] + RND) >>> 30;
            rs[k] = ta[k] + tb[k];
            if (rs[k] > MAXV)
            begin
                res_next[k] = MAXV[CB-1:0];
            end
            else if (rs[k] < MINV)
            begin
                res_next[k] = MINV[CB-1:0];
            end
            else
            begin
                res_next[k] = rs[k][CB-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            o_vld_reg <= w_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = o_vld_reg;
    assign res_x     = res_reg[0];
    assign res_y     = res_reg[1];
    assign res_z     = res_reg[2];
    assign res_s     = res_reg[3];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // An accepted transaction enters the first stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> p_vld_reg)
        else $error("accepted transaction did not enter the pipeline");

    // A stalled result freezes the front of the pipeline.
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(p_vld_reg) && $stable(d_vld_reg))
        else $error("pipeline moved while the output was stalled");

    // The slerp branch only sees a cosine below one.
    a_slerp_range: assert property (@(posedge clk) disable iff (!rst_n)
        (d_vld_reg && d_side_reg[SL_BIT]) |-> (d_c30_reg < SLERP_LIM))
        else $error("slerp branch taken with cosine out of range");

    // Selected weights never exceed 2.0.
    a_weight_max: assert property (@(posedge clk) disable iff (!rst_n)
        dc_vld[Q_BITS] |-> ((wt[0] <= W_MAX[31:0]) && (wt[1] <= W_MAX[31:0])))
        else $error("interpolation weight above limit");

endmodule

// ===== src/qslerp_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square-root cell
// Decides one result bit of a restoring integer square root and hands the
// remainder, partial root and side data to the next cell.
// ----------------------------------------------------------------------------
module qslerp_sqrt_cell #(
    parameter int BIT    = 30,
    parameter int SIDE_W = 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  logic                           vld_in,
    input  logic [qslerp_pkg::SQ_W-1:0]    rem_in,
    input  logic [qslerp_pkg::ROOT_W-1:0]  root_in,
    input  logic [SIDE_W-1:0]              side_in,
    output logic                           vld_out,
    output logic [qslerp_pkg::SQ_W-1:0]    rem_out,
    output logic [qslerp_pkg::ROOT_W-1:0]  root_out,
    output logic [SIDE_W-1:0]              side_out
);
    import qslerp_pkg::*;

    logic [SQ_W-1:0]   trial;
    logic              take;
    logic              vld_reg;
    logic [SQ_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [SIDE_W-1:0] side_reg;

    // Growth of the square when this bit is set: r*2^(BIT+1) + 2^(2*BIT).
    always_comb
    begin
        trial     = (SQ_W'(root_in) << (BIT + 1)) + (SQ_W'(1) << (2 * BIT));
        take      = (rem_in >= trial);
        rem_next  = take ? (rem_in - trial) : rem_in;
        root_next = take ? (root_in | (ROOT_W'(1) << BIT)) : root_in;
    end

    // Valid bit of this stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    // Data of this stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

// ===== src/qslerp_vec_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vectoring CORDIC cell
// One micro-rotation that drives y toward zero and accumulates the angle.
// ----------------------------------------------------------------------------
module qslerp_vec_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             vld_in,
    input  logic signed [qslerp_pkg::CW-1:0] x_in,
    input  logic signed [qslerp_pkg::CW-1:0] y_in,
    input  logic signed [qslerp_pkg::CW-1:0] z_in,
    input  logic [SIDE_W-1:0]                side_in,
    output logic                             vld_out,
    output logic signed [qslerp_pkg::CW-1:0] x_out,
    output logic signed [qslerp_pkg::CW-1:0] y_out,
    output logic signed [qslerp_pkg::CW-1:0] z_out,
    output logic [SIDE_W-1:0]                side_out
);
    import qslerp_pkg::*;

    localparam int IDX = STEP % 32;

    logic signed [CW-1:0] xs, ys, ang;
    logic                 vld_reg;
    logic signed [CW-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [SIDE_W-1:0]    side_reg;

    // Rotate toward the positive x axis.
    always_comb
    begin
        xs  = x_in >>> STEP;
        ys  = y_in >>> STEP;
        ang = signed'(CW'(ATAN_Q30[IDX]));
        if (y_in > 0)
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ang;
        end
        else
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ang;
        end
    end

    // Valid bit of this stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    // Data of this stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;

endmodule

// ===== src/qslerp_rot_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation CORDIC cell
// One micro-rotation for each of the two sine lanes, driving the residual
// angle toward zero.
// ----------------------------------------------------------------------------
module qslerp_rot_cell #(
    parameter int STEP   = 0,
    parameter int SIDE_W = 1
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             vld_in,
    input  logic signed [qslerp_pkg::CW-1:0] x_in [2],
    input  logic signed [qslerp_pkg::CW-1:0] y_in [2],
    input  logic signed [qslerp_pkg::CW-1:0] z_in [2],
    input  logic [SIDE_W-1:0]                side_in,
    output logic                             vld_out,
    output logic signed [qslerp_pkg::CW-1:0] x_out [2],
    output logic signed [qslerp_pkg::CW-1:0] y_out [2],
    output logic signed [qslerp_pkg::CW-1:0] z_out [2],
    output logic [SIDE_W-1:0]                side_out
);
    import qslerp_pkg::*;

    localparam int IDX = STEP % 32;

    logic signed [CW-1:0] xs [2];
    logic signed [CW-1:0] ys [2];
    logic signed [CW-1:0] ang;
    logic                 vld_reg;
    logic signed [CW-1:0] x_reg [2];
    logic signed [CW-1:0] x_next [2];
    logic signed [CW-1:0] y_reg [2];
    logic signed [CW-1:0] y_next [2];
    logic signed [CW-1:0] z_reg [2];
    logic signed [CW-1:0] z_next [2];
    logic [SIDE_W-1:0]    side_reg;

    // Both lanes rotate by the same step angle.
    always_comb
    begin
        ang = signed'(CW'(ATAN_Q30[IDX]));
        for (int l = 0; l < 2; l++)
        begin
            xs[l] = x_in[l] >>> STEP;
            ys[l] = y_in[l] >>> STEP;
            if (z_in[l] >= 0)
            begin
                x_next[l] = x_in[l] - ys[l];
                y_next[l] = y_in[l] + xs[l];
                z_next[l] = z_in[l] - ang;
            end
            else
            begin
                x_next[l] = x_in[l] + ys[l];
                y_next[l] = y_in[l] - xs[l];
                z_next[l] = z_in[l] + ang;
            end
        end
    end

    // Valid bit of this stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    // Data of this stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign x_out    = x_reg;
    assign y_out    = y_reg;
    assign z_out    = z_reg;
    assign side_out = side_reg;

endmodule

// ===== src/qslerp_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider cell
// Decides one quotient bit of a restoring division for each of the two
// weight lanes, which share one divisor.
// ----------------------------------------------------------------------------
module qslerp_div_cell #(
    parameter int K      = 32,
    parameter int SIDE_W = 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            vld_in,
    input  logic [qslerp_pkg::ROOT_W-1:0]   den_in,
    input  logic [qslerp_pkg::DIV_W-1:0]    rem_in [2],
    input  logic [qslerp_pkg::Q_BITS-1:0]   q_in [2],
    input  logic [SIDE_W-1:0]               side_in,
    output logic                            vld_out,
    output logic [qslerp_pkg::ROOT_W-1:0]   den_out,
    output logic [qslerp_pkg::DIV_W-1:0]    rem_out [2],
    output logic [qslerp_pkg::Q_BITS-1:0]   q_out [2],
    output logic [SIDE_W-1:0]               side_out
);
    import qslerp_pkg::*;

    logic [DIV_W-1:0]  dk;
    logic              vld_reg;
    logic [ROOT_W-1:0] den_reg;
    logic [DIV_W-1:0]  rem_reg [2];
    logic [DIV_W-1:0]  rem_next [2];
    logic [Q_BITS-1:0] q_reg [2];
    logic [Q_BITS-1:0] q_next [2];
    logic [SIDE_W-1:0] side_reg;

    // Subtract the shifted divisor where it fits.
    always_comb
    begin
        dk = DIV_W'(den_in) << K;
        for (int l = 0; l < 2; l++)
        begin
            if (rem_in[l] >= dk)
            begin
                rem_next[l] = rem_in[l] - dk;
                q_next[l]   = q_in[l] | (Q_BITS'(1) << K);
            end
            else
            begin
                rem_next[l] = rem_in[l];
                q_next[l]   = q_in[l];
            end
        end
    end

    // Valid bit of this stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    // Data of this stage.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg  <= den_in;
            rem_reg  <= rem_next;
            q_reg    <= q_next;
            side_reg <= side_in;
        end
    end

    assign vld_out  = vld_reg;
    assign den_out  = den_reg;
    assign rem_out  = rem_reg;
    assign q_out    = q_reg;
    assign side_out = side_reg;

endmodule
